/* rtl/adsr_eg_pkg.sv */
// Shared widths, constants and codes of the ADSR envelope generator.
package adsr_eg_pkg;

  localparam int unsigned LVL_W      = 25;
  localparam int unsigned STEP_W     = 26;
  localparam int unsigned TICK_W     = 20;
  localparam int unsigned MAG_W      = 25;
  localparam int unsigned STAGE_W    = 3;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned OUT_BITS_DEF = 16;

  localparam logic [LVL_W-1:0]  ONE_Q24   = LVL_W'(1 << 24);
  localparam logic [LVL_W-1:0]  LEVEL_MAX = '1;

  localparam logic [TICK_W-1:0] TICKS_RST   = TICK_W'(4800);
  localparam logic [LVL_W-1:0]  SUSTAIN_RST = LVL_W'(8388608);

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 2'd3;

  // Stage codes
  localparam logic [STAGE_W-1:0] STG_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] STG_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] STG_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] STG_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] STG_RELEASE = 3'd4;

endpackage

/* rtl/adsr_envelope_generator.sv */
// Top level of the linear ADSR envelope generator with its tick sequencer.
//
// Usage: each request on the slave stream (s_tdata bit 0 = note_gate) is one
// sample tick. The block answers every tick with one item on the master
// stream: the envelope level mapped onto 0.5..1.0 of the output code and
// the stage after that tick. The user must write timing values on the cfg
// port only while no tick is in flight; the block does not enforce this.
// Sequencing: a tick without a step change passes IDLE, EDGE, CHECK, MUL
// and OUT; a gate edge waits in WAIT1 and the decay start in WAIT2 for a
// division on the shared serial divider, and the level scaling is one
// registered multiply in MUL.
// Throughput: one tick at a time; s_tready is high only between ticks.
// A finished result sits in the output register, so the next tick is taken
// while it waits; a stalled receiver holds the following result back in
// the sequencer until the register frees.
// Reset: level, step, stage and gate history clear to zero (idle), the
// timing registers return to 4800 ticks and sustain to one half.
module adsr_envelope_generator
  import adsr_eg_pkg::*;
#(
  parameter int unsigned OUT_BITS = OUT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] note_gate
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [((OUT_BITS+3+7)/8)*8-1:0] m_tdata,  // level_code, then stage_now
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned M_W    = ((OUT_BITS + 3 + 7) / 8) * 8;
  localparam int unsigned PROD_W = STEP_W + OUT_BITS;
  localparam logic [OUT_BITS-1:0] MAX_CODE = '1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EDGE, ST_WAIT1, ST_CHECK, ST_WAIT2, ST_MUL, ST_OUT
  } state_t;

  state_t state;

  logic [TICK_W-1:0] attack_ticks, decay_ticks, release_ticks;
  logic [LVL_W-1:0]  sustain_level;

  logic [LVL_W-1:0]         env_level;
  logic signed [STEP_W-1:0] env_step;
  logic [STAGE_W-1:0]       env_stage;
  logic                     gate_prev;
  logic                     gate;
  logic [PROD_W-1:0]        prod;

  logic signed [STEP_W:0]   level_sum;
  logic [LVL_W-1:0]         level_next;
  logic                     div_start, div_done;
  logic signed [STEP_W-1:0] div_num, div_q;
  logic [TICK_W-1:0]        div_den;
  logic                     start_decay;
  logic                     enter_sustain;
  logic [OUT_BITS:0]        code_raw;
  logic [OUT_BITS-1:0]      code;

  assign s_tready = (state == ST_IDLE);

  // add the step and clamp into the level range
  assign level_sum = $signed({2'b00, env_level}) + $signed({env_step[STEP_W-1], env_step});
  always_comb begin
    if (level_sum < 0) begin
      level_next = '0;
    end else if (level_sum > $signed({2'b00, LEVEL_MAX})) begin
      level_next = LEVEL_MAX;
    end else begin
      level_next = level_sum[LVL_W-1:0];
    end
  end

  assign start_decay   = env_level[LVL_W-1] && !env_step[STEP_W-1] && (env_step != '0);
  assign enter_sustain = (env_level <= sustain_level) && env_step[STEP_W-1]
                         && (env_stage == STG_DECAY);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = attack_ticks;
    unique case (state)
      ST_EDGE: begin
        if (gate && !gate_prev) begin
          div_start = 1'b1;
          div_num   = $signed({1'b0, ONE_Q24}) - $signed({1'b0, env_level});
          div_den   = attack_ticks;
        end else if (!gate && gate_prev) begin
          div_start = 1'b1;
          div_num   = -$signed({1'b0, env_level});
          div_den   = release_ticks;
        end
      end
      ST_CHECK: begin
        if (start_decay) begin
          div_start = 1'b1;
          div_num   = $signed({1'b0, sustain_level}) - $signed({1'b0, ONE_Q24});
          div_den   = decay_ticks;
        end
      end
      default: begin
      end
    endcase
  end

  adsr_eg_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign code_raw = prod[STEP_W-1+OUT_BITS:STEP_W-1];
  assign code     = code_raw[OUT_BITS] ? MAX_CODE : code_raw[OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= TICKS_RST;
      decay_ticks   <= TICKS_RST;
      sustain_level <= SUSTAIN_RST;
      release_ticks <= TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ATTACK:  attack_ticks  <= cfg_wdata[TICK_W-1:0];
        REG_DECAY:   decay_ticks   <= cfg_wdata[TICK_W-1:0];
        REG_SUSTAIN: sustain_level <= cfg_wdata[LVL_W-1:0];
        REG_RELEASE: release_ticks <= cfg_wdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      env_level <= '0;
      env_step  <= '0;
      env_stage <= STG_IDLE;
      gate_prev <= 1'b0;
      gate      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            env_level <= level_next;
            gate      <= s_tdata[0];
            state     <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          if (gate && !gate_prev) begin
            env_stage <= STG_ATTACK;
            state     <= ST_WAIT1;
          end else if (!gate && gate_prev) begin
            env_stage <= STG_RELEASE;
            state     <= ST_WAIT1;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_WAIT1: begin
          if (div_done) begin
            env_step <= div_q;
            state    <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          gate_prev <= gate;
          if (start_decay) begin
            // pin at full scale and head toward the sustain level
            env_level <= ONE_Q24;
            env_stage <= STG_DECAY;
            state     <= ST_WAIT2;
          end else if (enter_sustain) begin
            env_step  <= '0;
            env_stage <= STG_SUSTAIN;
            state     <= ST_MUL;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_WAIT2: begin
          if (div_done) begin
            env_step <= div_q;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'({1'b0, env_level} + {1'b0, ONE_Q24}) * PROD_W'(MAX_CODE);
          state <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= M_W'({env_stage, code});
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while a tick is in progress");
  a_sustain_flat: assert property (@(posedge clk) disable iff (rst)
    env_stage == STG_SUSTAIN |-> env_step == '0)
    else $error("sustain stage with a nonzero step");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_WAIT1 || state == ST_WAIT2))
    else $error("divider finished outside a wait state");
  a_stage_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_BITS+2:OUT_BITS] <= STG_RELEASE)
    else $error("result carries an unknown stage code");
`endif

endmodule

/* rtl/adsr_eg_divider.sv */
// Serial restoring divider, signed numerator by unsigned tick count, truncating.
module adsr_eg_divider
  import adsr_eg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [STEP_W-1:0] num,
  input  logic [TICK_W-1:0]        den,
  output logic                     done,
  output logic signed [STEP_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(MAG_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [TICK_W:0]    rem;
  logic [MAG_W-1:0]   acc;
  logic [TICK_W-1:0]  divisor;
  logic               neg;

  logic [STEP_W-1:0]  num_abs;
  logic [TICK_W:0]    trial;
  logic               fits;

  assign num_abs = num[STEP_W-1] ? STEP_W'(-num) : STEP_W'(num);
  assign trial   = {rem[TICK_W-1:0], acc[MAG_W-1]};
  assign fits    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      if (start) begin
        busy    <= 1'b1;
        done    <= 1'b0;
        count   <= '0;
        rem     <= '0;
        acc     <= num_abs[MAG_W-1:0];
        neg     <= num[STEP_W-1];
        // a zero tick count acts as one
        divisor <= (den == '0) ? TICK_W'(1) : den;
      end else if (busy) begin
        rem   <= fits ? (trial - {1'b0, divisor}) : trial;
        acc   <= {acc[MAG_W-2:0], fits};
        count <= count + CNT_W'(1);
        done  <= (count == CNT_W'(MAG_W - 1));
        if (count == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quo = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("divider did not start");
  a_done_after: assert property (@(posedge clk) disable iff (rst) done |-> !busy && $past(busy))
    else $error("divider done without a finished run");
`endif

endmodule

/* dv/adsr_envelope_generator_tb.sv */
// Self-checking testbench for the linear ADSR envelope generator.
module adsr_envelope_generator_tb;
  import adsr_eg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          M_W        = ((OUT_BITS_DEF + 3 + 7) / 8) * 8;
  localparam int          CYCLE_CAP  = 500000;
  localparam int          DRAIN_WAIT = 80;
  localparam logic [19:0] TICKS_TOP  = 20'hFFFFF;
  localparam logic [24:0] SUS_TOP    = 25'h1FFFFFF;
  localparam logic [24:0] SUS_ONE    = 25'h1000000;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic [15:0]        code;
  } env_res_t;

  // Tracks level, step and stage per tick and checks the produced codes.
  class adsr_scoreboard;
    localparam longint ONE_LVL  = 64'sd1 << 24;
    localparam longint LVL_TOP  = (64'sd1 << 25) - 1;
    localparam longint STEP_TOP = (64'sd1 << 25) - 1;
    localparam longint STEP_BOT = -(64'sd1 << 25);
    localparam longint CODE_TOP = (64'sd1 << OUT_BITS_DEF) - 1;

    logic [19:0]        atk_ticks, dcy_ticks, rel_ticks;
    logic [24:0]        sus_lvl;
    longint             level, step;
    logic [STAGE_W-1:0] stage;
    bit                 gate_q;
    env_res_t           pending_levels[$];
    int                 errors, ticks_in, results_seen;

    function new();
      atk_ticks = TICKS_RST;
      dcy_ticks = TICKS_RST;
      rel_ticks = TICKS_RST;
      sus_lvl   = SUSTAIN_RST;
      level     = 0;
      step      = 0;
      stage     = STG_IDLE;
      gate_q    = 1'b0;
      errors    = 0;
    endfunction

    function longint step_div(longint num, logic [19:0] ticks);
      longint d, q;
      d = (ticks == 0) ? 64'sd1 : longint'(ticks);
      q = num / d;
      if (q > STEP_TOP) q = STEP_TOP;
      else if (q < STEP_BOT) q = STEP_BOT;
      return q;
    endfunction

    function void note_tick(bit gate);
      longint   code;
      env_res_t res;
      level = level + step;
      if (level < 0) level = 0;
      if (level > LVL_TOP) level = LVL_TOP;
      if (!gate_q && gate) begin
        step  = step_div(ONE_LVL - level, atk_ticks);
        stage = STG_ATTACK;
      end else if (gate_q && !gate) begin
        step  = step_div(-level, rel_ticks);
        stage = STG_RELEASE;
      end
      // the step chosen this tick decides the full-scale pin
      if (level >= ONE_LVL && step > 0) begin
        level = ONE_LVL;
        step  = step_div(longint'(sus_lvl) - ONE_LVL, dcy_ticks);
        stage = STG_DECAY;
      end else if (level <= longint'(sus_lvl) && step < 0 && stage == STG_DECAY) begin
        step  = 0;
        stage = STG_SUSTAIN;
      end
      gate_q = gate;
      code = ((level + ONE_LVL) * CODE_TOP) >>> 25;
      if (code > CODE_TOP) code = CODE_TOP;
      res.code  = code[15:0];
      res.stage = stage;
      pending_levels.push_back(res);
      ticks_in++;
    endfunction

    function void check_result(logic [M_W-1:0] data);
      env_res_t want;
      logic [15:0]        got_code;
      logic [STAGE_W-1:0] got_stage;
      got_code  = data[15:0];
      got_stage = data[16 +: STAGE_W];
      results_seen++;
      if (pending_levels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d with no tick pending: code %0d stage %0d",
                   results_seen, got_code, got_stage);
        return;
      end
      want = pending_levels.pop_front();
      if (got_code !== want.code || got_stage !== want.stage) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: level_code exp %0d got %0d, stage exp %0d got %0d",
                   results_seen, want.code, got_code, want.stage, got_stage);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;     // [0] note_gate
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_W-1:0]        m_tdata;          // [15:0] level_code, [18:16] stage_now
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_ATTACK;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  adsr_scoreboard sb;
  bit             idle_on;
  bit             long_hold;
  bit             gate_lvl;
  int             cycle_cnt;
  int             phases_run;

  adsr_envelope_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_CAP) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random stalls only when idling is on, plus one long hold on request.
  initial begin
    int stall_cnt;
    stall_cnt = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall_cnt > 0) begin
        stall_cnt--;
      end else if (long_hold) begin
        long_hold = 1'b0;
        stall_cnt = 300;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_cnt = $urandom_range(1, 5);
      end
      m_tready <= (stall_cnt == 0);
    end
  end

  task automatic send_tick(input bit gate);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, gate};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_tick(gate);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [19:0] a, input logic [19:0] d,
                           input logic [24:0] s, input logic [19:0] r);
    wait_drained();
    // let any division still in flight finish
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ATTACK;
    cfg_wdata <= CFG_DATA_W'(a);
    @(posedge clk);
    cfg_addr  <= REG_DECAY;
    cfg_wdata <= CFG_DATA_W'(d);
    @(posedge clk);
    cfg_addr  <= REG_SUSTAIN;
    cfg_wdata <= CFG_DATA_W'(s);
    @(posedge clk);
    cfg_addr  <= REG_RELEASE;
    cfg_wdata <= CFG_DATA_W'(r);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.atk_ticks = a;
    sb.dcy_ticks = d;
    sb.sus_lvl   = s;
    sb.rel_ticks = r;
  endtask

  task automatic send_gates(input bit seq[]);
    foreach (seq[i]) send_tick(seq[i]);
  endtask

  // Alternate note-on and note-off runs; most runs take a random length up to
  // max_run, a few are short glitches.
  task automatic run_notes(input int n_items, input int max_run, input bit pause_mid);
    int sent, run_len;
    sent = 0;
    while (sent < n_items) begin
      run_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                              : $urandom_range(1, max_run);
      gate_lvl = !gate_lvl;
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        send_tick(gate_lvl);
        sent++;
        if (pause_mid && sent == n_items / 2) wait_drained();
      end
    end
  endtask

  initial begin
    logic [19:0] a, d, r;
    logic [24:0] s;
    int          max_run;
    sb         = new();
    idle_on    = 1'b0;
    long_hold  = 1'b0;
    gate_lvl   = 1'b0;
    phases_run = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset timing: idle, attack start, release start.
    send_gates('{1'b0, 1'b1, 1'b1, 1'b0, 1'b0});
    // Zero ticks act as one; sustain at zero.
    configure(20'd0, 20'd1, 25'd0, 20'd1);
    send_gates('{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    // Release while attack overshoots full scale, then sustain above full scale.
    configure(20'd3, 20'd2, SUS_TOP, 20'd2);
    send_gates('{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                 1'b1, 1'b1});
    // Longest timing.
    configure(TICKS_TOP, TICKS_TOP, SUS_ONE, TICKS_TOP);
    send_gates('{1'b0, 1'b1, 1'b0});
    gate_lvl = 1'b0;

    for (int p = 0; p < 8; p++) begin
      if (p == 6) begin
        a = 20'($urandom);
        d = 20'($urandom);
        r = 20'($urandom);
        s = 25'($urandom);
        max_run = 40;
      end else begin
        a = 20'($urandom_range(0, 12));
        d = 20'($urandom_range(0, 12));
        r = 20'($urandom_range(0, 12));
        case ($urandom_range(0, 3))
          0:       s = 25'd0;
          1:       s = SUS_ONE;
          2:       s = 25'($urandom_range(0, 32'h1000000));
          default: s = 25'($urandom_range(32'h1000000, 32'h1FFFFFF));
        endcase
        max_run = 2 * (a + d + r) + 6;
      end
      configure(a, d, s, r);
      idle_on = (p % 3 != 2) && (p != 7);
      if (p == 2) long_hold = 1'b1;
      run_notes(150, max_run, p == 3);
      phases_run++;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d gate ticks over %0d timing settings, %0d envelope results checked",
             sb.ticks_in, phases_run + 4, sb.results_seen);
    $display("stages idle through release, overshoot release and out-of-range sustain");
    if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
